/* src/d2d_pkg.sv */
// shared types and constants of the disparity to depth block
// no dependencies

package d2d_pkg;

    localparam int QW = 40;

    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_BASELINE = 3'd4;
    localparam logic [2:0] CFG_XYZ_EN   = 3'd5;

    localparam logic [23:0] RST_FOCAL_X  = 24'd128000;
    localparam logic [23:0] RST_FOCAL_Y  = 24'd128000;
    localparam logic [19:0] RST_CENTER_X = 20'd163840;
    localparam logic [19:0] RST_CENTER_Y = 20'd122880;
    localparam logic [23:0] RST_BASELINE = 24'd60000;

    localparam logic [39:0] CAP_POS = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] CAP_NEG = 40'h80_0000_0000;

    typedef struct packed {
        logic [23:0] fx;
        logic [23:0] fy;
        logic [19:0] cx;
        logic [19:0] cy;
        logic [23:0] b;
        logic        xyz;
    } t_cfg;

    typedef struct packed {
        logic       vld;
        logic       ok;
        logic       negx;
        logic       negy;
        logic [2:0] ovf;
    } t_side;

    typedef struct packed {
        logic [19:0]   d1;
        logic [43:0]   dy;
        logic [19:0]   rd;
        logic [19:0]   rx;
        logic [43:0]   ry;
        logic [QW-1:0] qd;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
    } t_div;

    typedef struct packed {
        logic [49:0] md;
        logic [45:0] mx;
        logic [69:0] my;
        logic [19:0] d1;
        logic [43:0] dy;
    } t_num;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] depth_um;
        logic [39:0] x_um;
        logic [39:0] y_um;
        logic        saturated;
    } t_res;

endpackage

/* src/d2d_pix_if.sv */
// pixel input channel: valid, ready and pixel fields
// no dependencies

interface d2d_pix_if;
    logic               valid;
    logic               ready;
    logic        [10:0] pixel_col;
    logic        [10:0] pixel_row;
    logic               mask_bit;
    logic signed [15:0] disparity_q4;

    modport source(output valid, pixel_col, pixel_row, mask_bit, disparity_q4, input ready);
    modport sink(input valid, pixel_col, pixel_row, mask_bit, disparity_q4, output ready);
endinterface

/* src/d2d_res_if.sv */
// result output channel: valid, ready and result fields
// no dependencies

interface d2d_res_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic        [31:0] depth_um;
    logic signed [39:0] x_um;
    logic signed [39:0] y_um;
    logic               saturated;

    modport source(output valid, valid_res, depth_um, x_um, y_um, saturated, input ready);
    modport sink(input valid, valid_res, depth_um, x_um, y_um, saturated, output ready);
endinterface

/* src/disparity_to_depth_xyz.sv */
// top level: stereo disparity to depth and xyz, front pipeline and divider cell chain
// depends on d2d_pkg, d2d_pix_if, d2d_res_if, d2d_front, d2d_cell
// throughput: one pixel per cycle while the skid stage is empty, set by 40 divider cells at one quotient bit each
// output register plus skid stage; pipeline stalls only while the skid is full
// reset: synchronous active low, clears valid flags and loads default calibration

module disparity_to_depth_xyz #(
    parameter int IMAGE_WIDTH  = 2048,
    parameter int IMAGE_HEIGHT = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [23:0]      i_cfg_data,
    d2d_pix_if.sink          i_pix,
    d2d_res_if.source        o_res
);

    d2d_pkg::t_cfg  r_cfg;
    d2d_pkg::t_side side[d2d_pkg::QW+1];
    d2d_pkg::t_div  div[d2d_pkg::QW+1];
    d2d_pkg::t_num  num;
    d2d_pkg::t_res  n_res;
    d2d_pkg::t_res  r_ores;
    d2d_pkg::t_res  r_sres;

    logic r_ov;
    logic r_sv;
    logic en;
    logic f_vld;
    logic f_ok;
    logic f_negx;
    logic f_negy;
    logic p_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fx  <= d2d_pkg::RST_FOCAL_X;
            r_cfg.fy  <= d2d_pkg::RST_FOCAL_Y;
            r_cfg.cx  <= d2d_pkg::RST_CENTER_X;
            r_cfg.cy  <= d2d_pkg::RST_CENTER_Y;
            r_cfg.b   <= d2d_pkg::RST_BASELINE;
            r_cfg.xyz <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                d2d_pkg::CFG_FOCAL_X:  r_cfg.fx  <= i_cfg_data;
                d2d_pkg::CFG_FOCAL_Y:  r_cfg.fy  <= i_cfg_data;
                d2d_pkg::CFG_CENTER_X: r_cfg.cx  <= i_cfg_data[19:0];
                d2d_pkg::CFG_CENTER_Y: r_cfg.cy  <= i_cfg_data[19:0];
                d2d_pkg::CFG_BASELINE: r_cfg.b   <= i_cfg_data;
                d2d_pkg::CFG_XYZ_EN:   r_cfg.xyz <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en          = !r_sv;
    assign i_pix.ready = en;

    d2d_front #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_cfg  (r_cfg),
        .i_vld  (i_pix.valid),
        .i_col  (i_pix.pixel_col),
        .i_row  (i_pix.pixel_row),
        .i_mask (i_pix.mask_bit),
        .i_disp (i_pix.disparity_q4),
        .o_vld  (f_vld),
        .o_ok   (f_ok),
        .o_negx (f_negx),
        .o_negy (f_negy),
        .o_num  (num)
    );

    // load the first cell: remainder from the top dividend bits, overflow precheck
    always_comb begin
        side[0].vld    = f_vld;
        side[0].ok     = f_ok;
        side[0].negx   = f_negx;
        side[0].negy   = f_negy;
        side[0].ovf[0] = {10'b0, num.md[49:40]} >= num.d1;
        side[0].ovf[1] = {14'b0, num.mx[45:40]} >= num.d1;
        side[0].ovf[2] = {14'b0, num.my[69:40]} >= num.dy;
        div[0].d1      = num.d1;
        div[0].dy      = num.dy;
        div[0].rd      = {10'b0, num.md[49:40]};
        div[0].rx      = {14'b0, num.mx[45:40]};
        div[0].ry      = {14'b0, num.my[69:40]};
        div[0].qd      = num.md[39:0];
        div[0].qx      = num.mx[39:0];
        div[0].qy      = num.my[39:0];
    end

    for (genvar k = 0; k < d2d_pkg::QW; k++) begin : g_cell
        d2d_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_side (side[k]),
            .i_div  (div[k]),
            .o_side (side[k+1]),
            .o_div  (div[k+1])
        );
    end

    logic        sat_d;
    logic        sat_x;
    logic        sat_y;
    logic [39:0] cap_x;
    logic [39:0] cap_y;
    logic [39:0] mag_x;
    logic [39:0] mag_y;

    always_comb begin
        d2d_pkg::t_side s;
        d2d_pkg::t_div  v;
        s     = side[d2d_pkg::QW];
        v     = div[d2d_pkg::QW];
        p_v   = s.vld;
        cap_x = s.negx ? d2d_pkg::CAP_NEG : d2d_pkg::CAP_POS;
        cap_y = s.negy ? d2d_pkg::CAP_NEG : d2d_pkg::CAP_POS;
        sat_d = s.ovf[0] || (v.qd[39:32] != 8'd0);
        sat_x = s.ovf[1] || (v.qx > cap_x);
        sat_y = s.ovf[2] || (v.qy > cap_y);
        mag_x = sat_x ? cap_x : v.qx;
        mag_y = sat_y ? cap_y : v.qy;
        n_res = '0;
        if (s.ok) begin
            n_res.valid_res = 1'b1;
            n_res.depth_um  = sat_d ? 32'hFFFF_FFFF : v.qd[31:0];
            n_res.saturated = sat_d;
            if (r_cfg.xyz) begin
                n_res.x_um      = s.negx ? 40'(-mag_x) : mag_x;
                n_res.y_um      = s.negy ? 40'(-mag_y) : mag_y;
                n_res.saturated = sat_d || sat_x || sat_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_ov || o_res.ready) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= p_v;
                end
            end else if (en && p_v) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_res.ready) begin
            r_ores <= r_sv ? r_sres : n_res;
        end else if (en && p_v) begin
            r_sres <= n_res;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.valid_res = r_ores.valid_res;
    assign o_res.depth_um  = r_ores.depth_um;
    assign o_res.x_um      = r_ores.x_um;
    assign o_res.y_um      = r_ores.y_um;
    assign o_res.saturated = r_ores.saturated;

endmodule

/* src/d2d_cell.sv */
// one divider cell: one restoring step for depth, x and y quotients
// depends on d2d_pkg

module d2d_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  d2d_pkg::t_side i_side,
    input  d2d_pkg::t_div  i_div,
    output d2d_pkg::t_side o_side,
    output d2d_pkg::t_div  o_div
);

    d2d_pkg::t_side r_side;
    d2d_pkg::t_div  r_div;
    d2d_pkg::t_div  n_div;

    logic [20:0] tmp_d;
    logic [20:0] tmp_x;
    logic [44:0] tmp_y;
    logic        ge_d;
    logic        ge_x;
    logic        ge_y;

    always_comb begin
        tmp_d = {i_div.rd, i_div.qd[d2d_pkg::QW-1]};
        tmp_x = {i_div.rx, i_div.qx[d2d_pkg::QW-1]};
        tmp_y = {i_div.ry, i_div.qy[d2d_pkg::QW-1]};
        ge_d  = tmp_d >= {1'b0, i_div.d1};
        ge_x  = tmp_x >= {1'b0, i_div.d1};
        ge_y  = tmp_y >= {1'b0, i_div.dy};
        n_div    = i_div;
        n_div.rd = ge_d ? 20'(tmp_d - {1'b0, i_div.d1}) : tmp_d[19:0];
        n_div.rx = ge_x ? 20'(tmp_x - {1'b0, i_div.d1}) : tmp_x[19:0];
        n_div.ry = ge_y ? 44'(tmp_y - {1'b0, i_div.dy}) : tmp_y[43:0];
        n_div.qd = {i_div.qd[d2d_pkg::QW-2:0], ge_d};
        n_div.qx = {i_div.qx[d2d_pkg::QW-2:0], ge_x};
        n_div.qy = {i_div.qy[d2d_pkg::QW-2:0], ge_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_side = r_side;
    assign o_div  = r_div;

endmodule

/* src/d2d_front.sv */
// front pipeline: validity, offsets, products and dividends
// depends on d2d_pkg

module d2d_front #(
    parameter int IMAGE_WIDTH  = 2048,
    parameter int IMAGE_HEIGHT = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  d2d_pkg::t_cfg      i_cfg,
    input  logic               i_vld,
    input  logic        [10:0] i_col,
    input  logic        [10:0] i_row,
    input  logic               i_mask,
    input  logic signed [15:0] i_disp,
    output logic               o_vld,
    output logic               o_ok,
    output logic               o_negx,
    output logic               o_negy,
    output d2d_pkg::t_num      o_num
);

    logic [4:0]  r_vld;
    logic [4:0]  r_ok;
    logic [4:0]  r_negx;
    logic [4:0]  r_negy;

    logic [14:0] r_s1_d;
    logic [19:0] r_s1_magx;
    logic [19:0] r_s1_magy;

    logic [14:0] r_s2_d;
    logic [47:0] r_s2_pn;
    logic [43:0] r_s2_px;
    logic [43:0] r_s2_pf;
    logic [38:0] r_s2_pdy;

    logic [14:0] r_s3_d;
    logic [47:0] r_s3_pn;
    logic [43:0] r_s3_px;
    logic [45:0] r_s3_pyl;
    logic [45:0] r_s3_pyh;
    logic [38:0] r_s3_pdy;

    logic [67:0] r_s4_py;
    logic [49:0] r_s4_md;
    logic [45:0] r_s4_mx;
    logic [38:0] r_s4_pdy;
    logic [14:0] r_s4_d;

    d2d_pkg::t_num r_s5_num;

    logic        n_ok;
    logic        n_negx;
    logic        n_negy;
    logic [19:0] c256;
    logic [19:0] r256;

    always_comb begin
        c256   = {1'b0, i_col, 8'b0};
        r256   = {1'b0, i_row, 8'b0};
        n_negx = i_cfg.cx > c256;
        n_negy = i_cfg.cy > r256;
        n_ok   = i_mask && !i_disp[15] && (i_disp != 16'sd0)
                 && (i_cfg.fx != 24'd0) && (i_cfg.fy != 24'd0) && (i_cfg.b != 24'd0)
                 && (32'(i_col) < 32'(IMAGE_WIDTH)) && (32'(i_row) < 32'(IMAGE_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok      <= {r_ok[3:0], n_ok};
            r_negx    <= {r_negx[3:0], n_negx};
            r_negy    <= {r_negy[3:0], n_negy};
            r_s1_d    <= i_disp[14:0];
            r_s1_magx <= n_negx ? 20'(i_cfg.cx - c256) : 20'(c256 - i_cfg.cx);
            r_s1_magy <= n_negy ? 20'(i_cfg.cy - r256) : 20'(r256 - i_cfg.cy);

            r_s2_d   <= r_s1_d;
            r_s2_pn  <= 48'(i_cfg.fx) * 48'(i_cfg.b);
            r_s2_px  <= 44'(r_s1_magx) * 44'(i_cfg.b);
            r_s2_pf  <= 44'(r_s1_magy) * 44'(i_cfg.fx);
            r_s2_pdy <= 39'(i_cfg.fy) * 39'(r_s1_d);

            r_s3_d   <= r_s2_d;
            r_s3_pn  <= r_s2_pn;
            r_s3_px  <= r_s2_px;
            r_s3_pyl <= 46'(r_s2_pf[21:0]) * 46'(i_cfg.b);
            r_s3_pyh <= 46'(r_s2_pf[43:22]) * 46'(i_cfg.b);
            r_s3_pdy <= r_s2_pdy;

            r_s4_py  <= 68'(r_s3_pyl) + {r_s3_pyh, 22'b0};
            r_s4_md  <= 50'({r_s3_pn, 1'b0}) + 50'({r_s3_d, 4'b0});
            r_s4_mx  <= 46'({r_s3_px, 1'b0}) + 46'({r_s3_d, 4'b0});
            r_s4_pdy <= r_s3_pdy;
            r_s4_d   <= r_s3_d;

            r_s5_num.md <= r_s4_md;
            r_s5_num.mx <= r_s4_mx;
            r_s5_num.my <= 70'({r_s4_py, 1'b0}) + 70'({r_s4_pdy, 4'b0});
            r_s5_num.d1 <= {r_s4_d, 5'b0};
            r_s5_num.dy <= {r_s4_pdy, 5'b0};
        end
    end

    assign o_vld  = r_vld[4];
    assign o_ok   = r_ok[4];
    assign o_negx = r_negx[4];
    assign o_negy = r_negy[4];
    assign o_num  = r_s5_num;

endmodule

/* tb/tb.sv */
// testbench for disparity_to_depth_xyz: directed table then random pixels per calibration set
// depends on d2d_pkg, d2d_pix_if, d2d_res_if and the block itself
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int         DRAIN_CYCLES = 60;

    typedef struct {
        logic [10:0]        col;
        logic [10:0]        row;
        logic               mask;
        logic signed [15:0] disp;
        bit                 typed;
        d2d_pkg::t_res      exp_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    d2d_pix_if pix ();
    d2d_res_if res ();

    disparity_to_depth_xyz i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix.sink),
        .o_res      (res.source)
    );

    always #2 i_clk = ~i_clk;

    d2d_pkg::t_cfg calib;
    d2d_pkg::t_res depth_queue[$];
    int   errors = 0;
    bit   calm = 0;
    bit   long_hold = 0;

    initial begin
        pix.valid = 1'b0;
        pix.pixel_col = '0;
        pix.pixel_row = '0;
        pix.mask_bit = 1'b0;
        pix.disparity_q4 = '0;
        res.ready = 1'b0;
    end

    function automatic logic [127:0] round_div(logic [127:0] num, logic [127:0] den,
                                               logic [127:0] cap, ref bit sat);
        logic [127:0] q;
        q = (2 * num + den) / (2 * den);
        if (q > cap) begin
            sat = 1;
            q = cap;
        end
        return q;
    endfunction

    function automatic d2d_pkg::t_res predict_depth(logic [10:0] col, logic [10:0] row,
                                                    logic mask, logic signed [15:0] disp);
        d2d_pkg::t_res r;
        bit            sat;
        logic [127:0]  den, q;
        longint        ox, oy;
        r = '0;
        sat = 0;
        if (!mask || disp <= 0 || calib.fx == 0 || calib.fy == 0 || calib.b == 0)
            return r;
        den = 128'(disp) * 16;
        r.depth_um = 32'(round_div(128'(calib.fx) * calib.b, den, 128'hFFFF_FFFF, sat));
        if (calib.xyz) begin
            ox = longint'(col) * 256 - longint'(calib.cx);
            oy = longint'(row) * 256 - longint'(calib.cy);
            q = round_div(128'(ox < 0 ? -ox : ox) * calib.b, den,
                          ox < 0 ? 128'(d2d_pkg::CAP_NEG) : 128'(d2d_pkg::CAP_POS), sat);
            r.x_um = ox < 0 ? 40'(-q) : 40'(q);
            q = round_div(128'(oy < 0 ? -oy : oy) * calib.fx * calib.b, den * calib.fy,
                          oy < 0 ? 128'(d2d_pkg::CAP_NEG) : 128'(d2d_pkg::CAP_POS), sat);
            r.y_um = oy < 0 ? 40'(-q) : 40'(q);
        end
        r.valid_res = 1'b1;
        r.saturated = sat;
        return r;
    endfunction

    task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            d2d_pkg::CFG_FOCAL_X:  calib.fx = data;
            d2d_pkg::CFG_FOCAL_Y:  calib.fy = data;
            d2d_pkg::CFG_CENTER_X: calib.cx = data[19:0];
            d2d_pkg::CFG_CENTER_Y: calib.cy = data[19:0];
            d2d_pkg::CFG_BASELINE: calib.b = data;
            d2d_pkg::CFG_XYZ_EN:   calib.xyz = data[0];
            default: ;
        endcase
    endtask

    task automatic load_calib(logic [23:0] fx, logic [23:0] fy, logic [19:0] cx,
                              logic [19:0] cy, logic [23:0] b, logic xyz);
        cfg_write(d2d_pkg::CFG_FOCAL_X, fx);
        cfg_write(d2d_pkg::CFG_FOCAL_Y, fy);
        cfg_write(d2d_pkg::CFG_CENTER_X, 24'(cx));
        cfg_write(d2d_pkg::CFG_CENTER_Y, 24'(cy));
        cfg_write(d2d_pkg::CFG_BASELINE, b);
        cfg_write(d2d_pkg::CFG_XYZ_EN, 24'(xyz));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        pix.valid <= 1'b0;
        while (depth_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // drives one pixel and returns after its transaction; valid stays high unless a gap follows
    task automatic send_pixel(logic [10:0] col, logic [10:0] row, logic mask,
                              logic signed [15:0] disp, bit typed, d2d_pkg::t_res exp_res);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            pix.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.pixel_col <= col;
        pix.pixel_row <= row;
        pix.mask_bit <= mask;
        pix.disparity_q4 <= disp;
        do @(posedge i_clk); while (!pix.ready);
        depth_queue.push_back(typed ? exp_res : predict_depth(col, row, mask, disp));
    endtask

    task automatic send_random(int count);
        logic signed [15:0] disp;
        int                 kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                disp = 16'($urandom_range(1, 32767) >> $urandom_range(0, 14));
            else if (kind == 7)
                disp = -16'($urandom_range(0, 32768));
            else
                disp = 16'($urandom);
            if (disp <= 0 && kind < 7)
                disp = 1;
            send_pixel(11'($urandom), 11'($urandom), kind != 9 ? 1'b1 : 1'($urandom),
                       disp, 0, '0);
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 0;
                stall = 300;
            end
            if (stall > 0) begin
                stall--;
                res.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 5) - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        d2d_pkg::t_res e;
        if (i_rst_n && res.valid && res.ready) begin
            if (depth_queue.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = depth_queue.pop_front();
                if (res.valid_res !== e.valid_res) begin
                    $error("valid_res expected %0d actual %0d", e.valid_res, res.valid_res);
                    errors++;
                end
                if (res.depth_um !== e.depth_um) begin
                    $error("depth_um expected %0d actual %0d", e.depth_um, res.depth_um);
                    errors++;
                end
                if (res.x_um !== e.x_um) begin
                    $error("x_um expected %0d actual %0d", $signed(e.x_um), res.x_um);
                    errors++;
                end
                if (res.y_um !== e.y_um) begin
                    $error("y_um expected %0d actual %0d", $signed(e.y_um), res.y_um);
                    errors++;
                end
                if (res.saturated !== e.saturated) begin
                    $error("saturated expected %0d actual %0d", e.saturated, res.saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_row table_rows[$];
        int   limit;
        table_rows = '{
            '{11'd640, 11'd480, 1'b1, 16'sd16, 1, '{1'b1, 32'd30000000, 40'd0, 40'd0, 1'b0}},
            '{11'd0, 11'd0, 1'b0, 16'sd100, 1, '0},
            '{11'd2047, 11'd2047, 1'b1, 16'sd0, 1, '0},
            '{11'd5, 11'd7, 1'b1, -16'sd1, 1, '0},
            '{11'd2047, 11'd0, 1'b1, -16'sd32768, 1, '0},
            '{11'd0, 11'd2047, 1'b0, 16'sd32767, 1, '0},
            '{11'd0, 11'd0, 1'b1, 16'sd1, 0, '0},
            '{11'd2047, 11'd2047, 1'b1, 16'sd1, 0, '0},
            '{11'd0, 11'd2047, 1'b1, 16'sd32767, 0, '0},
            '{11'd2047, 11'd0, 1'b1, 16'sd32767, 0, '0},
            '{11'd1365, 11'd682, 1'b1, 16'sd21845, 0, '0},
            '{11'd682, 11'd1365, 1'b1, 16'sd10922, 0, '0}
        };
        calib = '{d2d_pkg::RST_FOCAL_X, d2d_pkg::RST_FOCAL_Y, d2d_pkg::RST_CENTER_X,
                  d2d_pkg::RST_CENTER_Y, d2d_pkg::RST_BASELINE, 1'b1};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[k])
            send_pixel(table_rows[k].col, table_rows[k].row, table_rows[k].mask,
                       table_rows[k].disp, table_rows[k].typed, table_rows[k].exp_res);
        send_random(130);
        wait_idle();

        // extremes: depth and coordinate saturation, long hold-off on the result side
        load_calib(24'hFF_FFFF, 24'd1, 20'd0, 20'd524288, 24'd10000000, 1'b1);
        long_hold = 1;
        send_random(150);
        wait_idle();

        load_calib(24'd1, 24'hFF_FFFF, 20'd524288, 20'd0, 24'd1, 1'b0);
        send_random(120);
        wait_idle();

        // degenerate focal length, then a write to an unused index
        cfg_write(d2d_pkg::CFG_FOCAL_X, 24'd0);
        send_random(40);
        wait_idle();
        cfg_write(CFG_UNUSED, 24'h5A_5A5A);
        cfg_write(d2d_pkg::CFG_FOCAL_X, 24'd256000);
        send_random(60);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            load_calib(24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 16)),
                       24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 16)),
                       20'($urandom_range(0, 524288)), 20'($urandom_range(0, 524288)),
                       24'($urandom_range(1, 10000000) >> $urandom_range(0, 20)),
                       1'($urandom));
            if (p == 2)
                calm = 1;
            send_random(130);
            wait_idle();
        end

        @(negedge i_clk);
        pix.valid <= 1'b0;
        limit = 0;
        while (depth_queue.size() != 0 && limit < 10000) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && depth_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
src/d2d_pkg.sv
src/d2d_pix_if.sv
src/d2d_res_if.sv
src/d2d_cell.sv
src/d2d_front.sv
src/disparity_to_depth_xyz.sv
tb/tb.sv
